FILE: rtl/mfqs_pkg.sv
// Shared constants and payload types of the three-level feedback scheduler.
`default_nettype none
package mfqs_pkg;
    localparam int MAX_PROCS = 32;
    localparam int ID_W      = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TICK_BITS = 16;
    localparam int LEVELS    = 3;
    localparam int LVL_W     = 2;
    localparam int BURST_W   = 10;
    localparam int Q0_W      = 8;
    localparam int L1_W      = 10;
    localparam int CFG_W     = 10;
    localparam logic [BURST_W-1:0] COUNT_MAX = 10'd1023;
    localparam logic [0:0] REG_Q0 = 1'b0;
    localparam logic [0:0] REG_L1 = 1'b1;

    typedef struct packed {
        logic               arrival_valid;
        logic [4:0]         process_id;
        logic [BURST_W-1:0] burst_length;
    } t_in;

    typedef struct packed {
        logic [4:0] running_id;
        logic       idle;
        logic [1:0] run_level;
        logic       finished;
        logic       preempted;
    } t_out;

    typedef struct packed {
        logic [BURST_W-1:0]   burst;
        logic [BURST_W-1:0]   run_count;
        logic [TICK_BITS-1:0] stamp;
    } t_tbl;
endpackage
`default_nettype wire

FILE: rtl/mfqs_ram.sv
// Generic synchronous RAM, one write and one registered read port.
`default_nettype none
module mfqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/multilevel_feedback_queue_scheduler_core.sv
// Top level of the three-level feedback scheduler: sequencer over table and queue RAMs.
//
//  channel | direction | handshake           | payload
//  tick in | input     | i_valid / o_ready   | i_in  (mfqs_pkg::t_in)
//  result  | output    | o_valid / i_ready   | o_out (mfqs_pkg::t_out)
//  config  | input     | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// A tick steps through selection, an optional preemption and pop, and the run step before
// its result is registered. Each ordered insertion reads the new stamp and shifts later queue
// entries up one slot until an older or equal stamp is found; a full level skips it. There are
// up to three insertions a tick: the arrival, the preempted and the demoted process.
// Reset is synchronous, active low, and needs no clearing pass.
// A new tick is taken while the previous result waits in the output register; the tick
// after it holds in its last cycle until that result is taken.
`default_nettype none
module multilevel_feedback_queue_scheduler_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output      logic                      o_ready,
    input  wire mfqs_pkg::t_in             i_in,
    output      logic                      o_valid,
    input  wire logic                      i_ready,
    output      mfqs_pkg::t_out            o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [mfqs_pkg::CFG_W-1:0] i_cfg_data
);
    localparam int SAW = $clog2(mfqs_pkg::LEVELS * mfqs_pkg::MAX_PROCS);
    localparam int TW  = $bits(mfqs_pkg::t_tbl);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SEL  = 4'd1;
    localparam logic [3:0] S_PRE  = 4'd2;
    localparam logic [3:0] S_POPA = 4'd3;
    localparam logic [3:0] S_POPB = 4'd4;
    localparam logic [3:0] S_RUNA = 4'd5;
    localparam logic [3:0] S_RUNB = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;
    localparam logic [3:0] S_PUA  = 4'd8;
    localparam logic [3:0] S_PUB  = 4'd9;
    localparam logic [3:0] S_PUC  = 4'd10;
    localparam logic [3:0] S_PUD  = 4'd11;
    localparam logic [3:0] S_PUE  = 4'd12;

    logic [3:0] r_state, n_state, r_ret, n_ret;
    logic [mfqs_pkg::LVL_W-1:0] r_lv, n_lv, r_cur_level, n_cur_level;
    logic [mfqs_pkg::ID_W-1:0] r_pid, n_pid, r_cand, n_cand, r_cur, n_cur;
    logic [mfqs_pkg::CNT_W-1:0] r_pos, n_pos;
    logic [mfqs_pkg::TICK_BITS-1:0] r_new_stamp, n_new_stamp, r_tick, n_tick;
    logic [mfqs_pkg::ID_W-1:0] r_head [mfqs_pkg::LEVELS];
    logic [mfqs_pkg::ID_W-1:0] n_head [mfqs_pkg::LEVELS];
    logic [mfqs_pkg::CNT_W-1:0] r_cnt [mfqs_pkg::LEVELS];
    logic [mfqs_pkg::CNT_W-1:0] n_cnt [mfqs_pkg::LEVELS];
    logic r_cur_valid, n_cur_valid, r_acc, n_acc, r_pre, n_pre, r_out_valid, n_out_valid;
    logic [mfqs_pkg::Q0_W-1:0] r_q0;
    logic [mfqs_pkg::L1_W-1:0] r_l1;
    mfqs_pkg::t_out r_res, n_res, r_out, n_out;

    logic                       tbl_we, tbl_re, slot_we, slot_re;
    logic [mfqs_pkg::ID_W-1:0]  tbl_waddr, tbl_raddr;
    mfqs_pkg::t_tbl             tbl_wdata, tbl_q;
    logic [TW-1:0]              tbl_q_raw;
    logic [SAW-1:0]             slot_waddr, slot_raddr;
    logic [mfqs_pkg::ID_W-1:0]  slot_wdata, slot_q;

    logic [mfqs_pkg::ID_W-1:0]  ins_idx;
    logic [mfqs_pkg::BURST_W-1:0] rc;

    assign tbl_q = mfqs_pkg::t_tbl'(tbl_q_raw);

    mfqs_ram #(.WIDTH(TW), .DEPTH(mfqs_pkg::MAX_PROCS)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(TW'(tbl_wdata)),
        .i_re   (tbl_re),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_q_raw)
    );

    mfqs_ram #(.WIDTH(mfqs_pkg::ID_W), .DEPTH(mfqs_pkg::LEVELS * mfqs_pkg::MAX_PROCS)) u_slot (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_re   (slot_re),
        .i_raddr(slot_raddr),
        .o_rdata(slot_q)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;
    assign ins_idx = r_head[r_lv] + r_pos[mfqs_pkg::ID_W-1:0];

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_lv = r_lv; n_pid = r_pid; n_cand = r_cand;
        n_cur = r_cur; n_cur_valid = r_cur_valid; n_cur_level = r_cur_level;
        n_pos = r_pos; n_new_stamp = r_new_stamp; n_tick = r_tick;
        n_head = r_head; n_cnt = r_cnt; n_acc = r_acc; n_pre = r_pre;
        n_res = r_res; n_out = r_out;
        n_out_valid = r_out_valid & ~i_ready;
        tbl_we = 1'b0; tbl_re = 1'b0; tbl_waddr = r_pid; tbl_raddr = r_pid;
        tbl_wdata = tbl_q;
        slot_we = 1'b0; slot_re = 1'b0;
        slot_waddr = {r_lv, ins_idx}; slot_raddr = {r_lv, r_head[r_lv]};
        slot_wdata = r_pid;
        rc = tbl_q.run_count;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_pre = 1'b0;
                    n_acc = 1'b0;
                    n_state = S_SEL;
                    if (i_in.arrival_valid && r_cnt[0] < mfqs_pkg::CNT_W'(mfqs_pkg::MAX_PROCS)) begin
                        tbl_we = 1'b1;
                        tbl_waddr = i_in.process_id[mfqs_pkg::ID_W-1:0];
                        tbl_wdata = '{burst: i_in.burst_length, run_count: '0, stamp: r_tick};
                        n_acc = 1'b1;
                        n_lv = '0;
                        n_pid = i_in.process_id[mfqs_pkg::ID_W-1:0];
                        n_ret = S_SEL;
                        n_state = S_PUA;
                    end
                end
            end
            S_SEL: begin
                n_state = S_RUNA;
                if (!r_cur_valid) begin
                    if (r_cnt[0] != '0) begin
                        n_lv = 2'd0; n_state = S_POPA;
                    end else if (r_cnt[1] != '0) begin
                        n_lv = 2'd1; n_state = S_POPA;
                    end else if (r_cnt[2] != '0) begin
                        n_lv = 2'd2; n_state = S_POPA;
                    end
                end else if (r_acc && r_cur_level != 2'd0) begin
                    n_pre = 1'b1;
                    n_lv = r_cur_level;
                    n_pid = r_cur;
                    n_ret = S_PRE;
                    n_state = S_PUA;
                end
            end
            S_PRE: begin
                n_lv = 2'd0;
                n_state = S_POPA;
            end
            S_POPA: begin
                slot_re = 1'b1;
                n_state = S_POPB;
            end
            S_POPB: begin
                n_cur = slot_q;
                n_head[r_lv] = r_head[r_lv] + 1'b1;
                n_cnt[r_lv] = r_cnt[r_lv] - 1'b1;
                n_cur_valid = 1'b1;
                n_cur_level = r_lv;
                n_state = S_RUNA;
            end
            S_RUNA: begin
                if (r_cur_valid) begin
                    tbl_re = 1'b1;
                    tbl_raddr = r_cur;
                    n_state = S_RUNB;
                end else begin
                    n_res = '{running_id: '0, idle: 1'b1, run_level: '0,
                              finished: 1'b0, preempted: r_pre};
                    n_state = S_DONE;
                end
            end
            S_RUNB: begin
                if (rc < mfqs_pkg::COUNT_MAX) begin
                    rc = rc + 1'b1;
                end
                tbl_we = 1'b1;
                tbl_waddr = r_cur;
                tbl_wdata = '{burst: tbl_q.burst, run_count: rc, stamp: tbl_q.stamp};
                n_res = '{running_id: r_cur, idle: 1'b0, run_level: r_cur_level,
                          finished: 1'b0, preempted: r_pre};
                n_state = S_DONE;
                n_pid = r_cur;
                n_ret = S_DONE;
                if (rc >= tbl_q.burst) begin
                    n_res.finished = 1'b1;
                    n_cur_valid = 1'b0;
                end else if (r_cur_level == 2'd0 && rc == {2'b00, r_q0}) begin
                    n_cur_valid = 1'b0; n_lv = 2'd1; n_state = S_PUA;
                end else if (r_cur_level <= 2'd1 && rc == r_l1) begin
                    n_cur_valid = 1'b0; n_lv = 2'd2; n_state = S_PUA;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out = r_res;
                    n_out_valid = 1'b1;
                    n_tick = r_tick + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PUA: begin
                if (r_cnt[r_lv] >= mfqs_pkg::CNT_W'(mfqs_pkg::MAX_PROCS)) begin
                    n_state = r_ret;
                end else begin
                    tbl_re = 1'b1;
                    tbl_raddr = r_pid;
                    n_pos = r_cnt[r_lv];
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                n_new_stamp = tbl_q.stamp;
                n_state = S_PUC;
            end
            S_PUC: begin
                if (r_pos == '0) begin
                    slot_we = 1'b1;
                    n_cnt[r_lv] = r_cnt[r_lv] + 1'b1;
                    n_state = r_ret;
                end else begin
                    slot_re = 1'b1;
                    slot_raddr = {r_lv, ins_idx - 1'b1};
                    n_state = S_PUD;
                end
            end
            S_PUD: begin
                n_cand = slot_q;
                tbl_re = 1'b1;
                tbl_raddr = slot_q;
                n_state = S_PUE;
            end
            S_PUE: begin
                slot_we = 1'b1;
                if (tbl_q.stamp > r_new_stamp) begin
                    slot_wdata = r_cand;
                    n_pos = r_pos - 1'b1;
                    n_state = S_PUC;
                end else begin
                    n_cnt[r_lv] = r_cnt[r_lv] + 1'b1;
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_cur_valid <= 1'b0;
            r_cur_level <= '0;
            r_cur <= '0;
            r_tick <= '0;
            r_out_valid <= 1'b0;
            r_acc <= 1'b0;
            r_pre <= 1'b0;
            r_q0 <= 8'd2;
            r_l1 <= 10'd6;
            for (int i = 0; i < mfqs_pkg::LEVELS; i++) begin
                r_head[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_cur_valid <= n_cur_valid;
            r_cur_level <= n_cur_level;
            r_cur <= n_cur;
            r_tick <= n_tick;
            r_out_valid <= n_out_valid;
            r_acc <= n_acc;
            r_pre <= n_pre;
            r_head <= n_head;
            r_cnt <= n_cnt;
            if (i_cfg_we) begin
                if (i_cfg_idx == mfqs_pkg::REG_Q0) begin
                    r_q0 <= i_cfg_data[mfqs_pkg::Q0_W-1:0];
                end else begin
                    r_l1 <= i_cfg_data[mfqs_pkg::L1_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lv <= n_lv;
        r_pid <= n_pid;
        r_cand <= n_cand;
        r_pos <= n_pos;
        r_new_stamp <= n_new_stamp;
        r_res <= n_res;
        r_out <= n_out;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= mfqs_pkg::CNT_W'(mfqs_pkg::MAX_PROCS)
        && r_cnt[1] <= mfqs_pkg::CNT_W'(mfqs_pkg::MAX_PROCS)
        && r_cnt[2] <= mfqs_pkg::CNT_W'(mfqs_pkg::MAX_PROCS))
        else $error("queue count overflow");
    a_cur_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_cur_level != 2'd3)
        else $error("bad running level");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second transaction taken mid-tick");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POPB |-> r_cnt[r_lv] != '0)
        else $error("pop from empty level");
endmodule
`default_nettype wire

FILE: test/multilevel_feedback_queue_scheduler_core_tb.sv
// Self-checking testbench of the three-level feedback scheduler core.
`default_nettype none
module multilevel_feedback_queue_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    mfqs_pkg::t_in  i_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    mfqs_pkg::t_out o_out;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [mfqs_pkg::CFG_W-1:0] i_cfg_data = '0;

    multilevel_feedback_queue_scheduler_core dut (.*);

    always #2 i_clk = ~i_clk;

    mfqs_pkg::t_in  tick_q[$];
    mfqs_pkg::t_out sched_q[$];
    int   errors = 0;
    int   sent_cnt = 0;
    int   taken_cnt = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_cnt = 0;
    bit   quiet = 1'b0;

    // scheduler state mirror
    logic [mfqs_pkg::Q0_W-1:0]      quantum;
    logic [mfqs_pkg::L1_W-1:0]      limit;
    logic [mfqs_pkg::TICK_BITS-1:0] ticks;
    logic [mfqs_pkg::BURST_W-1:0]   burst_of [mfqs_pkg::MAX_PROCS];
    logic [mfqs_pkg::BURST_W-1:0]   runs_of [mfqs_pkg::MAX_PROCS];
    logic [mfqs_pkg::TICK_BITS-1:0] stamp_of [mfqs_pkg::MAX_PROCS];
    logic [mfqs_pkg::ID_W-1:0]      slot [mfqs_pkg::LEVELS][mfqs_pkg::MAX_PROCS];
    int                             depth [mfqs_pkg::LEVELS];
    logic [mfqs_pkg::ID_W-1:0]      cur_id;
    bit                             cur_busy;
    int                             cur_lvl;

    function automatic void enqueue(int lv, logic [mfqs_pkg::ID_W-1:0] id);
        int pos;
        if (depth[lv] >= mfqs_pkg::MAX_PROCS) return;
        pos = depth[lv];
        while (pos > 0 && stamp_of[slot[lv][pos-1]] > stamp_of[id]) begin
            slot[lv][pos] = slot[lv][pos-1];
            pos--;
        end
        slot[lv][pos] = id;
        depth[lv]++;
    endfunction

    function automatic logic [mfqs_pkg::ID_W-1:0] dequeue(int lv);
        logic [mfqs_pkg::ID_W-1:0] id;
        id = slot[lv][0];
        for (int i = 1; i < depth[lv]; i++) slot[lv][i-1] = slot[lv][i];
        depth[lv]--;
        return id;
    endfunction

    function automatic mfqs_pkg::t_out schedule_tick(mfqs_pkg::t_in t);
        mfqs_pkg::t_out r;
        bit joined;
        logic [mfqs_pkg::BURST_W-1:0] rc;
        r = '0;
        r.idle = 1'b1;
        joined = 1'b0;
        if (t.arrival_valid && depth[0] < mfqs_pkg::MAX_PROCS) begin
            burst_of[t.process_id] = t.burst_length;
            runs_of[t.process_id]  = '0;
            stamp_of[t.process_id] = ticks;
            enqueue(0, t.process_id);
            joined = 1'b1;
        end
        if (!cur_busy) begin
            for (int lv = 0; lv < mfqs_pkg::LEVELS; lv++) begin
                if (depth[lv] > 0) begin
                    cur_id = dequeue(lv);
                    cur_lvl = lv;
                    cur_busy = 1'b1;
                    break;
                end
            end
        end else if (joined && cur_lvl != 0) begin
            enqueue(cur_lvl, cur_id);
            cur_id = dequeue(0);
            cur_lvl = 0;
            r.preempted = 1'b1;
        end
        if (cur_busy) begin
            rc = runs_of[cur_id];
            if (rc < mfqs_pkg::COUNT_MAX) rc++;
            runs_of[cur_id] = rc;
            r.idle = 1'b0;
            r.running_id = cur_id;
            r.run_level = cur_lvl[1:0];
            if (rc >= burst_of[cur_id]) begin
                r.finished = 1'b1;
                cur_busy = 1'b0;
            end else if (cur_lvl == 0 && rc == mfqs_pkg::BURST_W'(quantum)) begin
                enqueue(1, cur_id);
                cur_busy = 1'b0;
            end else if (cur_lvl <= 1 && rc == limit) begin
                enqueue(2, cur_id);
                cur_busy = 1'b0;
            end
        end
        ticks++;
        return r;
    endfunction

    // tick driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && taken_cnt != sent_cnt)) begin
            if (tick_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
                i_in <= tick_q.pop_front();
                i_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 400;
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || $urandom_range(99) >= 9;
        end
    end

    // predict on accepted ticks, check accepted results
    always @(posedge i_clk) begin
        mfqs_pkg::t_out e;
        if (i_rst_n && i_valid && o_ready) begin
            sched_q.push_back(schedule_tick(i_in));
            taken_cnt <= taken_cnt + 1;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (sched_q.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                e = sched_q.pop_front();
                if (o_out.running_id !== e.running_id) begin
                    $error("running_id exp %0d got %0d", e.running_id, o_out.running_id);
                    errors++;
                end
                if (o_out.idle !== e.idle) begin
                    $error("idle exp %0d got %0d", e.idle, o_out.idle);
                    errors++;
                end
                if (o_out.run_level !== e.run_level) begin
                    $error("run_level exp %0d got %0d", e.run_level, o_out.run_level);
                    errors++;
                end
                if (o_out.finished !== e.finished) begin
                    $error("finished exp %0d got %0d", e.finished, o_out.finished);
                    errors++;
                end
                if (o_out.preempted !== e.preempted) begin
                    $error("preempted exp %0d got %0d", e.preempted, o_out.preempted);
                    errors++;
                end
            end
        end
    end

    function automatic mfqs_pkg::t_in mk(bit av, int id, int burst);
        mfqs_pkg::t_in t;
        t.arrival_valid = av;
        t.process_id = id[4:0];
        t.burst_length = burst[mfqs_pkg::BURST_W-1:0];
        return t;
    endfunction

    task automatic drain();
        while (tick_q.size() > 0 || i_valid || sched_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_regs(int q0, int l1);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= mfqs_pkg::REG_Q0;
        i_cfg_data <= mfqs_pkg::CFG_W'(q0);
        @(negedge i_clk);
        i_cfg_idx <= mfqs_pkg::REG_L1;
        i_cfg_data <= mfqs_pkg::CFG_W'(l1);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        quantum = mfqs_pkg::Q0_W'(q0);
        limit = mfqs_pkg::L1_W'(l1);
    endtask

    task automatic random_ticks(int n, int arrive_pct);
        int b;
        for (int i = 0; i < n; i++) begin
            b = ($urandom_range(99) < 4) ? $urandom_range(1023) : $urandom_range(1, 12);
            tick_q.push_back(mk($urandom_range(99) < arrive_pct, $urandom_range(31), b));
        end
    endtask

    initial begin
        int q0s[6] = '{2, 1, 255, 3, 1, 0};
        int l1s[6] = '{6, 2, 1023, 10, 1023, 0};
        quantum = 8'd2;
        limit = 10'd6;
        ticks = '0;
        foreach (depth[i]) depth[i] = 0;
        cur_id = '0;
        cur_busy = 1'b0;
        cur_lvl = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle, short, longest burst, zero burst, id reuse, preemption
        tick_q.push_back(mk(0, 0, 0));
        tick_q.push_back(mk(1, 0, 1));
        tick_q.push_back(mk(1, 31, 1023));
        tick_q.push_back(mk(1, 5, 0));
        tick_q.push_back(mk(1, 31, 3));
        for (int i = 0; i < 8; i++) tick_q.push_back(mk(0, 0, 0));
        tick_q.push_back(mk(1, 10, 20));
        for (int i = 0; i < 7; i++) tick_q.push_back(mk(0, 0, 0));
        tick_q.push_back(mk(1, 21, 2));
        tick_q.push_back(mk(1, 10, 682));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_regs(q0s[ph], l1s[ph]);
            quiet = (ph == 3);
            if (ph == 2) begin
                // flood level 0 past its capacity while results are held off
                for (int i = 0; i < 45; i++) tick_q.push_back(mk(1, i, $urandom_range(1, 4)));
                hold_req++;
            end
            random_ticks(240, 30 + 12 * ph);
            drain();
        end
        quiet = 1'b0;

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/mfqs_pkg.sv
rtl/mfqs_ram.sv
rtl/multilevel_feedback_queue_scheduler_core.sv
test/multilevel_feedback_queue_scheduler_core_tb.sv
